>>> hdl/rebt_pkg.sv
package rebt_pkg;

   // Default width of the internal step accumulator
   localparam int COUNT_WIDTH_DEFAULT = 16;

   // Field widths
   localparam int STEP_WIDTH     = 16;
   localparam int TIMER_WIDTH    = 10;
   localparam int HOLD_WIDTH     = 11;
   localparam int CSR_ADDR_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 10;
   localparam int REQ_DATA_WIDTH = 8;
   localparam int RSP_DATA_WIDTH = 24;

   // Register indexes
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_ACTIVE_LEVEL   = 2'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_BUTTON_PRESENT = 2'd1;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_CHECK_INTERVAL = 2'd2;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_HOLD_CHECKS    = 2'd3;

   // Register reset values
   localparam logic [TIMER_WIDTH-1:0] CHECK_INTERVAL_RESET = 10'd10;
   localparam logic [TIMER_WIDTH-1:0] HOLD_CHECKS_RESET    = 10'd120;

   typedef enum logic [1:0] {
      BTN_OPEN     = 2'd0,
      BTN_CLICKED  = 2'd1,
      BTN_HELD     = 2'd2,
      BTN_RELEASED = 2'd3
   } btn_status_type;

   // Input item, listed from the top bit down; clk_level is tdata bit 0
   typedef struct packed {
      logic take_button;
      logic take_delta;
      logic btn_level;
      logic dt_level;
      logic clk_level;
   } req_item_type;

   // Result item, step_count in the low bits
   typedef struct packed {
      btn_status_type              button_event;
      logic signed [STEP_WIDTH-1:0] step_count;
   } rsp_item_type;

endpackage

>>> hdl/rotary_encoder_button_tracker.sv
// Rotary encoder and push-button tracker, driven by a 1 ms tick stream.
//
// req_*: one item per tick with the sampled encoder clock, data and button
//   levels plus two fetch flags. rsp_*: exactly one result item per input item,
//   carrying the signed step count and the button status after that tick.
// csr_*: plain write port for the four settings; write only while idle.
//
// The tracker state and the result are formed combinationally for the accepted
// item and registered in the output register, or in the skid register while the
// output stalls, before showing on rsp_*. One item per cycle is taken while
// req_tready is high; the edge, timer and hold counters update with each item.
//
// When the receiver stalls, the waiting result holds in the output register
// and one further item is taken into a skid register; req_tready drops only
// while the skid register is full.
//
// Reset (synchronous, active high) empties both output registers, restores
// the register defaults and returns the tracker to its idle state: clock seen
// as active, button open, count and timers zero.
module rotary_encoder_button_tracker #(
   parameter int COUNT_WIDTH = rebt_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: clk_level, dt_level, btn_level, take_delta, take_button, zero fill
   input  logic [rebt_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // rsp_tdata: step_count[15:0], button_event[17:16], zero fill
   output logic [rebt_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_we,
   input  logic [rebt_pkg::CSR_ADDR_WIDTH-1:0] csr_addr,
   input  logic [rebt_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);
   import rebt_pkg::*;

   localparam logic signed [COUNT_WIDTH-1:0] COUNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
   localparam logic signed [COUNT_WIDTH-1:0] COUNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
   localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};
   localparam logic [HOLD_WIDTH-1:0]  HOLD_MAX  = {HOLD_WIDTH{1'b1}};

   // settings
   logic                   active_level_ff;
   logic                   button_present_ff;
   logic [TIMER_WIDTH-1:0] check_interval_ff;
   logic [TIMER_WIDTH-1:0] hold_checks_ff;

   // tracker state
   logic                          prev_clk_active_ff, prev_clk_active_in;
   logic                          prev_btn_active_ff, prev_btn_active_in;
   logic signed [COUNT_WIDTH-1:0] steps_ff, steps_in;
   btn_status_type                status_ff, status_in;
   logic [HOLD_WIDTH-1:0]         held_ff, held_in;
   logic [TIMER_WIDTH-1:0]        timer_ff, timer_in;

   // output and skid registers
   rsp_item_type out_item_ff, skid_item_ff, new_item;
   logic         out_valid_ff, skid_valid_ff;

   req_item_type                  req;
   logic                          accept, out_fire;
   logic                          clk_active, btn_active, sample;
   logic signed [COUNT_WIDTH-1:0] steps_tick;
   btn_status_type                status_tick;
   logic [TIMER_WIDTH-1:0]        timer_inc;
   logic [HOLD_WIDTH-1:0]         held_inc;

   assign req        = req_item_type'(req_tdata[$bits(req_item_type)-1:0]);
   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = out_valid_ff;
   assign out_fire   = out_valid_ff && rsp_tready;
   assign rsp_tdata  = {{(RSP_DATA_WIDTH-$bits(rsp_item_type)){1'b0}}, out_item_ff};

   // Next tracker state for the item at the input
   always_comb begin
      clk_active  = (req.clk_level == active_level_ff);
      btn_active  = (req.btn_level == active_level_ff);
      steps_tick  = steps_ff;
      // count one step on the edge into the active level, saturating
      if (clk_active && !prev_clk_active_ff) begin
         if (req.dt_level) begin
            if (steps_ff != COUNT_MAX) steps_tick = steps_ff + 1'b1;
         end else begin
            if (steps_ff != COUNT_MIN) steps_tick = steps_ff - 1'b1;
         end
      end
      prev_clk_active_in = clk_active;

      timer_inc = (timer_ff != TIMER_MAX) ? timer_ff + 1'b1 : timer_ff;
      sample    = button_present_ff && (timer_inc >= check_interval_ff);
      timer_in  = sample ? '0 : timer_inc;

      held_inc           = (held_ff != HOLD_MAX) ? held_ff + 1'b1 : held_ff;
      held_in            = held_ff;
      status_tick        = status_ff;
      prev_btn_active_in = prev_btn_active_ff;
      if (sample) begin
         prev_btn_active_in = btn_active;
         if (btn_active) begin
            if (prev_btn_active_ff) begin
               held_in = held_inc;
               if (held_inc > {1'b0, hold_checks_ff}) status_tick = BTN_HELD;
            end else begin
               status_tick = BTN_CLICKED;
            end
         end else begin
            if (status_ff == BTN_HELD) status_tick = BTN_RELEASED;
            held_in = '0;
         end
      end

      new_item.step_count   = STEP_WIDTH'(steps_tick);
      new_item.button_event = status_tick;

      // fetches clear after the result is formed; a held status stays
      steps_in  = req.take_delta ? '0 : steps_tick;
      status_in = (req.take_button && status_tick != BTN_HELD) ? BTN_OPEN : status_tick;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_level_ff    <= 1'b0;
         button_present_ff  <= 1'b1;
         check_interval_ff  <= CHECK_INTERVAL_RESET;
         hold_checks_ff     <= HOLD_CHECKS_RESET;
         prev_clk_active_ff <= 1'b1;
         prev_btn_active_ff <= 1'b0;
         steps_ff           <= '0;
         status_ff          <= BTN_OPEN;
         held_ff            <= '0;
         timer_ff           <= '0;
         out_valid_ff       <= 1'b0;
         skid_valid_ff      <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               REG_ACTIVE_LEVEL:   active_level_ff   <= csr_wdata[0];
               REG_BUTTON_PRESENT: button_present_ff <= csr_wdata[0];
               REG_CHECK_INTERVAL: check_interval_ff <= csr_wdata[TIMER_WIDTH-1:0];
               REG_HOLD_CHECKS:    hold_checks_ff    <= csr_wdata[TIMER_WIDTH-1:0];
            endcase
         end

         // advance the tracker once per accepted item
         if (accept) begin
            prev_clk_active_ff <= prev_clk_active_in;
            prev_btn_active_ff <= prev_btn_active_in;
            steps_ff           <= steps_in;
            status_ff          <= status_in;
            held_ff            <= held_in;
            timer_ff           <= timer_in;
         end

         // output register with one skid stage behind it
         if (skid_valid_ff) begin
            if (out_fire) begin
               out_item_ff   <= skid_item_ff;
               skid_valid_ff <= 1'b0;
            end
         end else if (accept) begin
            if (!out_valid_ff || out_fire) begin
               out_item_ff  <= new_item;
               out_valid_ff <= 1'b1;
            end else begin
               skid_item_ff  <= new_item;
               skid_valid_ff <= 1'b1;
            end
         end else if (out_fire) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

endmodule

>>> hdl/rebt_checker.sv
module rebt_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [rebt_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready
);
   import rebt_pkg::*;

   localparam int ITEM_BITS = $bits(rsp_item_type);

   // a stalled result holds until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or vanished");

   // reset leaves no result pending
   assert property (@(posedge clock) reset |=> !rsp_tvalid && req_tready)
      else $error("result pending after reset");

   // input stalls only while a result is waiting at the output
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with empty output");

   // an item accepted into an idle block shows on the output in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> rsp_tvalid)
      else $error("accepted item produced no result");

   // zero fill above the result fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_WIDTH-1:ITEM_BITS] == '0)
      else $error("result fill bits not zero");

endmodule

bind rotary_encoder_button_tracker rebt_checker u_rebt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import rebt_pkg::*;

   // Stretch of the long receiver hold-off, and the cycle budget of the whole run
   localparam int unsigned HOLD_OFF_CYCLES = 300;
   localparam int unsigned CYCLE_LIMIT     = 1_500_000;

   localparam logic signed [STEP_WIDTH-1:0] STEP_MAX = 16'sh7FFF;
   localparam logic signed [STEP_WIDTH-1:0] STEP_MIN = 16'sh8000;

   logic                      clock = 1'b0;
   logic                      reset;
   logic [REQ_DATA_WIDTH-1:0] req_tdata;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic                      csr_we;
   logic [CSR_ADDR_WIDTH-1:0] csr_addr;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata;

   // Idle control shared between the stimulus and the receiver pacing
   logic req_gaps_on  = 1'b1;
   logic rsp_gaps_on  = 1'b1;
   logic rsp_hold_off = 1'b0;

   int unsigned error_count = 0;
   int unsigned cycle_count = 0;

   // Settings as the tracker should currently hold them
   logic                   cfg_active_level;
   logic                   cfg_button_present;
   logic [TIMER_WIDTH-1:0] cfg_check_interval;
   logic [TIMER_WIDTH-1:0] cfg_hold_checks;

   // Mirror of the tracker state
   logic                          trk_prev_clk_on;
   logic                          trk_prev_btn_on;
   logic signed [STEP_WIDTH-1:0]  trk_steps;
   btn_status_type                trk_button;
   logic [HOLD_WIDTH-1:0]         trk_held;
   logic [TIMER_WIDTH-1:0]        trk_timer;

   // Step count and button status awaited on the result channel, oldest first
   rsp_item_type tracker_results_q[$];

   rotary_encoder_button_tracker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Abandon the run if it overstays its budget
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Advance the mirrored tracker by one tick and queue the result it gives.
   // The result is formed before the fetch flags clear anything.
   function automatic void track_tick(input req_item_type item);
      logic         clk_on;
      logic         btn_on;
      rsp_item_type res;
      clk_on = (item.clk_level == cfg_active_level);
      if (clk_on && !trk_prev_clk_on) begin
         if (item.dt_level) begin
            if (trk_steps != STEP_MAX) trk_steps = trk_steps + 16'sd1;
         end else begin
            if (trk_steps != STEP_MIN) trk_steps = trk_steps - 16'sd1;
         end
      end
      trk_prev_clk_on = clk_on;

      // Timer saturates; an interval of zero samples on every tick
      if (trk_timer != '1) trk_timer = trk_timer + 1'b1;
      if (cfg_button_present && trk_timer >= cfg_check_interval) begin
         trk_timer = '0;
         btn_on = (item.btn_level == cfg_active_level);
         if (btn_on) begin
            if (trk_prev_btn_on) begin
               if (trk_held != '1) trk_held = trk_held + 1'b1;
               if (trk_held > {1'b0, cfg_hold_checks}) trk_button = BTN_HELD;
            end else begin
               trk_button = BTN_CLICKED;
            end
         end else begin
            if (trk_button == BTN_HELD) trk_button = BTN_RELEASED;
            trk_held = '0;
         end
         trk_prev_btn_on = btn_on;
      end

      res.step_count   = trk_steps;
      res.button_event = trk_button;
      tracker_results_q.push_back(res);

      if (item.take_delta) trk_steps = '0;
      if (item.take_button && trk_button != BTN_HELD) trk_button = BTN_OPEN;
   endfunction

   // Build an item from pin states given as active or not, so that the
   // directed sequences read the same whatever the active level is
   function automatic req_item_type pins(input logic clk_on, input logic dt,
                                         input logic btn_on, input logic take_d,
                                         input logic take_b);
      req_item_type item;
      item.clk_level   = clk_on ? cfg_active_level : ~cfg_active_level;
      item.dt_level    = dt;
      item.btn_level   = btn_on ? cfg_active_level : ~cfg_active_level;
      item.take_delta  = take_d;
      item.take_button = take_b;
      return item;
   endfunction

   // Offer one item, with an occasional gap first, and hold it until taken
   task automatic send_tick(input req_item_type item);
      if (req_gaps_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_WIDTH'(item);
      track_tick(item);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Drop valid and wait until every queued result has come back, plus slack
   // for the output and skid registers
   task automatic settle_tracker();
      req_tvalid <= 1'b0;
      while (tracker_results_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic program_reg(input logic [CSR_ADDR_WIDTH-1:0] idx,
                              input logic [CSR_DATA_WIDTH-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_ACTIVE_LEVEL:   cfg_active_level   = value[0];
         REG_BUTTON_PRESENT: cfg_button_present = value[0];
         REG_CHECK_INTERVAL: cfg_check_interval = value[TIMER_WIDTH-1:0];
         REG_HOLD_CHECKS:    cfg_hold_checks    = value[TIMER_WIDTH-1:0];
         default: ;
      endcase
   endtask

   // Write all four settings once the tracker has gone quiet
   task automatic apply_settings(input logic level, input logic present,
                                 input logic [TIMER_WIDTH-1:0] interval,
                                 input logic [TIMER_WIDTH-1:0] hold);
      settle_tracker();
      program_reg(REG_ACTIVE_LEVEL, CSR_DATA_WIDTH'(level));
      program_reg(REG_BUTTON_PRESENT, CSR_DATA_WIDTH'(present));
      program_reg(REG_CHECK_INTERVAL, interval);
      program_reg(REG_HOLD_CHECKS, hold);
   endtask

   // Receiver pacing: random stalls, or one long hold-off on request
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_off) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_hold_off = 1'b0;
            rsp_tready <= 1'b1;
         end else if (rsp_gaps_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Compare every accepted result with the oldest expectation
   always @(posedge clock) begin : result_check
      rsp_item_type got;
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(rsp_item_type)-1:0];
         if (tracker_results_q.size() == 0) begin
            $error("result item arrived with no tick pending: %h", rsp_tdata);
            error_count++;
         end else begin
            want = tracker_results_q.pop_front();
            if (got.step_count !== want.step_count) begin
               $error("step_count: expected %0d, actual %0d",
                      want.step_count, got.step_count);
               error_count++;
            end
            if (got.button_event !== want.button_event) begin
               $error("button_event: expected %0d, actual %0d",
                      want.button_event, got.button_event);
               error_count++;
            end
         end
      end
   end

   // Reset settings: active low, ten-tick sampling; the first sample lands on
   // the tenth tick and sees a fresh press
   task automatic test_reset_defaults();
      int i;
      send_tick(pins(1, 1, 1, 0, 0));
      for (i = 0; i < 5; i++) begin
         send_tick(pins(0, 1, 1, 0, 0));
         send_tick(pins(1, 1, 1, 0, 0));
      end
      send_tick(pins(0, 0, 1, 0, 0));
      send_tick(pins(1, 0, 1, 1, 1));
      send_tick(pins(1, 0, 0, 0, 0));
   endtask

   // Count up and down on active-going clock edges only, clear on fetch
   task automatic test_step_edges();
      int i;
      apply_settings(1'b1, 1'b1, 10'd5, 10'd3);
      for (i = 0; i < 3; i++) begin
         send_tick(pins(0, 1, 0, 0, 0));
         send_tick(pins(1, 1, 0, 0, 0));
      end
      // dt moves while clock rests: no step
      send_tick(pins(1, 0, 0, 0, 0));
      send_tick(pins(1, 1, 0, 1, 0));
      for (i = 0; i < 4; i++) begin
         send_tick(pins(0, 0, 0, 0, 0));
         send_tick(pins(1, 0, 0, 0, 0));
      end
      send_tick(pins(0, 1, 0, 1, 0));
   endtask

   // Click, hold, fetch while held, release and fetch after release, sampling
   // on every tick
   task automatic test_button_events();
      apply_settings(1'b1, 1'b1, 10'd0, 10'd1);
      send_tick(pins(0, 0, 0, 0, 0));
      send_tick(pins(0, 0, 1, 0, 0));
      send_tick(pins(0, 0, 1, 0, 1));
      send_tick(pins(0, 0, 1, 0, 0));
      send_tick(pins(0, 0, 1, 0, 1));
      send_tick(pins(0, 0, 0, 0, 0));
      send_tick(pins(0, 0, 0, 0, 0));
      send_tick(pins(0, 0, 0, 0, 1));
      send_tick(pins(0, 0, 0, 0, 0));
      // Every second tick, with no hold threshold at all
      apply_settings(1'b0, 1'b1, 10'd2, 10'd0);
      repeat (6) send_tick(pins(0, 0, 1, 0, 0));
      repeat (4) send_tick(pins(0, 0, 0, 0, 0));
   endtask

   // Frozen button with the timer left to saturate, then an immediate sample
   // once handling is switched back on at the longest interval
   task automatic test_button_absent();
      apply_settings(1'b1, 1'b0, 10'd1023, 10'd120);
      repeat (1030) send_tick(pins(0, 0, 1, 0, 0));
      settle_tracker();
      program_reg(REG_BUTTON_PRESENT, CSR_DATA_WIDTH'(1'b1));
      repeat (3) send_tick(pins(0, 0, 1, 0, 1));
      send_tick(pins(0, 0, 0, 0, 1));
   endtask

   // Long hold threshold, sampled every tick
   task automatic test_long_hold();
      apply_settings(1'b1, 1'b1, 10'd0, 10'd200);
      send_tick(pins(0, 0, 0, 0, 0));
      repeat (210) send_tick(pins(0, 0, 1, 0, 0));
      send_tick(pins(0, 0, 1, 0, 1));
      send_tick(pins(0, 0, 0, 0, 0));
      send_tick(pins(0, 0, 0, 0, 1));
   endtask

   // Count down through zero into negative values and back up, with fetches
   task automatic test_count_sign();
      int i;
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      apply_settings(1'b1, 1'b0, 10'd1, 10'd1);
      send_tick(pins(1, 0, 0, 1, 0));
      for (i = 0; i < 20; i++) begin
         send_tick(pins(0, 0, 0, 0, 0));
         send_tick(pins(1, 0, 0, 0, 0));
      end
      send_tick(pins(1, 1, 0, 0, 0));
      for (i = 0; i < 12; i++) begin
         send_tick(pins(0, 1, 0, 0, 0));
         send_tick(pins(1, 1, 0, 0, 0));
      end
      send_tick(pins(1, 0, 0, 1, 0));
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
   endtask

   // Hold the result channel off while items keep coming, so the block fills
   // and stalls its input
   task automatic test_backpressure();
      int i;
      apply_settings(1'b0, 1'b1, 10'd1, 10'd2);
      req_gaps_on  = 1'b0;
      rsp_hold_off = 1'b1;
      for (i = 0; i < 40; i++) send_tick(pins(i[0], i[2], i[3], i[4], i[3]));
      req_gaps_on = 1'b1;
   endtask

   // Mostly clean rotations and press/release runs with random content, with
   // some raw noise; the last phases run without idling
   task automatic test_random_traffic();
      req_item_type item;
      int unsigned  btn_left;
      int unsigned  phase;
      int unsigned  n;
      logic         btn_down;
      logic         turn_up;
      logic         clk_on;
      logic [TIMER_WIDTH-1:0] interval;
      logic [TIMER_WIDTH-1:0] hold;
      btn_left = 0;
      btn_down = 1'b0;
      turn_up  = 1'b1;
      clk_on   = 1'b0;
      for (phase = 0; phase < 8; phase++) begin
         if (phase == 6) begin
            req_gaps_on = 1'b0;
            rsp_gaps_on = 1'b0;
         end
         case ($urandom_range(0, 9))
            0:       interval = 10'd1023;
            1, 2:    interval = TIMER_WIDTH'($urandom_range(5, 30));
            default: interval = TIMER_WIDTH'($urandom_range(0, 4));
         endcase
         case ($urandom_range(0, 9))
            0:       hold = 10'd1023;
            1:       hold = TIMER_WIDTH'($urandom_range(9, 1022));
            default: hold = TIMER_WIDTH'($urandom_range(0, 8));
         endcase
         apply_settings(1'($urandom_range(0, 1)), ($urandom_range(0, 7) != 0), interval, hold);
         for (n = 0; n < 65; n++) begin
            if (btn_left == 0) begin
               btn_down = ~btn_down;
               btn_left = btn_down ? $urandom_range(1, 60) : $urandom_range(1, 25);
            end
            btn_left--;
            if ($urandom_range(0, 19) == 0) turn_up = ~turn_up;
            if ($urandom_range(0, 2) != 0) clk_on = ~clk_on;
            if ($urandom_range(0, 9) == 0) begin
               item = req_item_type'(5'($urandom_range(0, 31)));
            end else begin
               item = pins(clk_on, turn_up, btn_down, ($urandom_range(0, 15) == 0),
                           ($urandom_range(0, 9) == 0));
            end
            send_tick(item);
         end
      end
   endtask

   initial begin
      // Hold every input at a known value from time zero
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_addr   <= '0;
      csr_wdata  <= '0;

      cfg_active_level   = 1'b0;
      cfg_button_present = 1'b1;
      cfg_check_interval = CHECK_INTERVAL_RESET;
      cfg_hold_checks    = HOLD_CHECKS_RESET;
      trk_prev_clk_on    = 1'b1;
      trk_prev_btn_on    = 1'b0;
      trk_steps          = '0;
      trk_button         = BTN_OPEN;
      trk_held           = '0;
      trk_timer          = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_step_edges();
      test_button_events();
      test_button_absent();
      test_long_hold();
      test_count_sign();
      test_backpressure();
      test_random_traffic();

      settle_tracker();
      repeat (8) @(posedge clock);
      if (error_count == 0 && tracker_results_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
